// File: src/hvn_pkg.sv
package hvn_pkg;

    // Widths of the normalizer datapath
    localparam int NCW   = 20;  // signed component into the normalizer
    localparam int NOW   = 16;  // signed Q2.14 component out of it
    localparam int MAGW  = NCW; // component magnitude
    localparam int SQW   = 32;  // sum of three squares of 15-bit magnitudes
    localparam int RTW   = 61;  // integer square root remainder and root
    localparam int NUMW  = 44;  // dividend: magnitude scaled by 2^28 plus half the length
    localparam int DSHW  = 46;  // divisor aligned to the top quotient bit
    localparam int QW    = 16;  // quotient bits
    localparam int CNTW  = 5;
    localparam int ROOT_STEPS = 30;
    localparam logic [QW-1:0] UNIT_Q = 16'd16384;

    localparam int HW   = 16;   // height width
    localparam int DIMW = 9;    // config register width

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam logic STAT_OK      = 1'b0;
    localparam logic STAT_OUTSIDE = 1'b1;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 2'd1;

    // Quadrants around the center point
    localparam logic [1:0] Q_UL = 2'd0;
    localparam logic [1:0] Q_UR = 2'd1;
    localparam logic [1:0] Q_DL = 2'd2;
    localparam logic [1:0] Q_DR = 2'd3;

    typedef logic signed [1:0] t_step;
    localparam t_step SP = 2'sb01;
    localparam t_step SZ = 2'sb00;
    localparam t_step SN = 2'sb11;

    typedef struct packed {
        t_step      ux;
        t_step      uy;
        t_step      wx;
        t_step      wy;
        logic [1:0] quad;
    } t_facet;

    typedef struct packed {
        logic signed [NCW-1:0] x;
        logic signed [NCW-1:0] y;
        logic signed [NCW-1:0] z;
    } t_vec;

    typedef struct packed {
        logic                  done;
        logic signed [NOW-1:0] x;
        logic signed [NOW-1:0] y;
        logic signed [NOW-1:0] z;
    } t_nrm_out;

    typedef enum logic [2:0] {
        NRM_IDLE,
        NRM_SHIFT,
        NRM_SQR,
        NRM_ROOT,
        NRM_DSET,
        NRM_DIV,
        NRM_DONE
    } t_nrm_state;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RDK,
        ST_CAPK,
        ST_TSEL,
        ST_RDU,
        ST_RDW,
        ST_CAPW,
        ST_NWAIT,
        ST_FIN,
        ST_FWAIT,
        ST_OUT
    } t_top_state;

    // Edge steps (u then w) and quadrant of each facet around the point
    function automatic t_facet facet_of(input logic odd, input logic [2:0] idx);
        t_facet f;
        case ({odd, idx})
            4'b0000: f = '{SZ, SN, SN, SZ, Q_UL};
            4'b0001: f = '{SP, SZ, SZ, SN, Q_UR};
            4'b0010: f = '{SN, SZ, SZ, SP, Q_DL};
            4'b0011: f = '{SZ, SP, SP, SZ, Q_DR};
            4'b1000: f = '{SN, SN, SN, SZ, Q_UL};
            4'b1001: f = '{SZ, SN, SN, SN, Q_UL};
            4'b1010: f = '{SP, SN, SZ, SN, Q_UR};
            4'b1011: f = '{SP, SZ, SP, SN, Q_UR};
            4'b1100: f = '{SN, SZ, SN, SP, Q_DL};
            4'b1101: f = '{SN, SP, SZ, SP, Q_DL};
            4'b1110: f = '{SP, SP, SP, SZ, Q_DR};
            4'b1111: f = '{SZ, SP, SP, SP, Q_DR};
            default: f = '{SZ, SZ, SZ, SZ, Q_UL};
        endcase
        return f;
    endfunction

endpackage

// File: src/hvn_if.sv
interface hvn_req_if;
    logic              valid;
    logic              ready;
    logic              action;
    logic [7:0]        row;
    logic [7:0]        col;
    logic signed [15:0] height;

    modport source(output valid, output action, output row, output col, output height,
                   input ready);
    modport sink(input valid, input action, input row, input col, input height,
                 output ready);
endinterface

interface hvn_res_if;
    logic              valid;
    logic              ready;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic              status;

    modport source(output valid, output normal_x, output normal_y, output normal_z,
                   output status, input ready);
    modport sink(input valid, input normal_x, input normal_y, input normal_z,
                 input status, output ready);
endinterface

// File: src/heightmap_vertex_normal.sv
// Height grid with vertex normal queries. Heights (signed Q8.8) live in one
// single-port RAM of MAX_ROWS x MAX_COLS entries, addressed row * MAX_COLS +
// col; entries hold garbage until written, and there is no clearing pass. A
// write request gives no result; an out-of-grid write is dropped. A query
// outside grid_rows x grid_cols returns a zero normal with status 1. An
// in-grid query reads the center height, then for each triangle that fits
// on the grid reads its two neighbor heights, forms the cross product and
// sends it through the shared normalizer; the summed triangle normals go
// through the normalizer once more. The normalizer scales the vector by up
// to 14 one-bit scaling steps, then forms the sum of squares, takes a
// bit-serial square root and runs three parallel 16-bit restoring
// dividers; a zero vector gives a zero result without these steps. A query
// visits 4 triangles when row and column parity match and 8 otherwise,
// skipping those that do not fit on the grid. One request is worked on at
// a time; a finished result waits in the output register while the next
// request is taken.
module heightmap_vertex_normal #(
    parameter int MAX_ROWS = 256,
    parameter int MAX_COLS = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [hvn_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [hvn_pkg::DIMW-1:0]      i_cfg_data,
    hvn_req_if.sink                       i_req,
    hvn_res_if.source                     o_res
);
    import hvn_pkg::*;

    localparam int AW  = $clog2(MAX_ROWS * MAX_COLS);
    localparam int RDW = ($clog2(MAX_ROWS + 1) > DIMW) ? $clog2(MAX_ROWS + 1) : DIMW;
    localparam int CDW = ($clog2(MAX_COLS + 1) > DIMW) ? $clog2(MAX_COLS + 1) : DIMW;

    t_top_state            r_state, n_state;
    logic [DIMW-1:0]       r_rows, r_cols;
    logic [7:0]            r_r, n_r, r_c, n_c;
    logic                  r_up, n_up, r_dn, n_dn, r_lf, n_lf, r_rt, n_rt;
    logic                  r_odd, n_odd;
    logic signed [HW-1:0]  r_k, n_k, r_hu, n_hu;
    logic [3:0]            r_t, n_t;
    logic signed [NCW-1:0] r_ax, n_ax, r_ay, n_ay, r_az, n_az;
    logic                  r_nstart, n_nstart;
    t_vec                  r_nvec, n_nvec;
    logic signed [NOW-1:0] r_fx, n_fx, r_fy, n_fy, r_fz, n_fz;
    logic                  r_fst, n_fst;
    logic                  r_ov, n_ov;
    logic signed [NOW-1:0] r_ox, n_ox, r_oy, n_oy, r_oz, n_oz;
    logic                  r_ost, n_ost;

    logic [RDW-1:0]   rows_eff;
    logic [CDW-1:0]   cols_eff;
    logic             in_grid;
    logic             req_take;
    t_facet           fct;
    logic             fct_en;
    logic [3:0]       t_max;
    logic [AW-1:0]    ram_addr;
    logic             ram_we;
    logic [HW-1:0]    ram_rdata;
    t_nrm_out         nrm;

    logic signed [HW:0]    du, dw;
    logic signed [NCW-1:0] cx, cy, cz;
    logic signed [2:0]     zs;

    // Step times height difference, step in {-1, 0, 1}
    function automatic logic signed [HW+1:0] smul(input t_step s, input logic signed [HW:0] d);
        logic signed [HW+1:0] e;
        e = {d[HW], d};
        case (s)
            SP:      return e;
            SN:      return -e;
            default: return '0;
        endcase
    endfunction

    function automatic logic signed [2:0] sprod(input t_step a, input t_step b);
        if (a == SZ || b == SZ) return 3'sd0;
        return (a == b) ? 3'sd1 : -3'sd1;
    endfunction

    function automatic logic [AW-1:0] grid_addr(input logic [7:0] r, input logic [7:0] c,
                                                input t_step dy, input t_step dx);
        logic [8:0] nr;
        logic [8:0] nc;
        nr = {1'b0, r} + {{7{dy[1]}}, dy};
        nc = {1'b0, c} + {{7{dx[1]}}, dx};
        return AW'(AW'(nr) * AW'(MAX_COLS) + AW'(nc));
    endfunction

    // Clamp the configured grid to the RAM size; a zero dimension counts as one
    always_comb begin
        rows_eff = RDW'(r_rows);
        if (r_rows == '0) rows_eff = RDW'(1);
        else if (RDW'(r_rows) > RDW'(MAX_ROWS)) rows_eff = RDW'(MAX_ROWS);
        cols_eff = CDW'(r_cols);
        if (r_cols == '0) cols_eff = CDW'(1);
        else if (CDW'(r_cols) > CDW'(MAX_COLS)) cols_eff = CDW'(MAX_COLS);
    end

    assign in_grid  = (RDW'(i_req.row) < rows_eff) && (CDW'(i_req.col) < cols_eff);
    assign req_take = i_req.valid && (r_state == ST_IDLE);
    assign i_req.ready = (r_state == ST_IDLE);

    assign fct   = facet_of(r_odd, r_t[2:0]);
    assign t_max = r_odd ? 4'd8 : 4'd4;

    always_comb begin
        case (fct.quad)
            Q_UL:    fct_en = r_up && r_lf;
            Q_UR:    fct_en = r_up && r_rt;
            Q_DL:    fct_en = r_dn && r_lf;
            Q_DR:    fct_en = r_dn && r_rt;
            default: fct_en = 1'b0;
        endcase
    end

    // Cross product of the two facet edges; x and y Q8.8, z scaled by 256
    assign du = {r_hu[HW-1], r_hu} - {r_k[HW-1], r_k};
    assign dw = {ram_rdata[HW-1], ram_rdata} - {r_k[HW-1], r_k};
    assign cx = NCW'(smul(fct.uy, dw) - smul(fct.wy, du));
    assign cy = NCW'(smul(fct.wx, du) - smul(fct.ux, dw));
    assign zs = sprod(fct.ux, fct.wy) - sprod(fct.uy, fct.wx);
    assign cz = $signed({{(NCW-11){zs[2]}}, zs, 8'b0});

    always_comb begin
        case (r_state)
            ST_IDLE: ram_addr = grid_addr(i_req.row, i_req.col, SZ, SZ);
            ST_RDU:  ram_addr = grid_addr(r_r, r_c, fct.uy, fct.ux);
            ST_RDW:  ram_addr = grid_addr(r_r, r_c, fct.wy, fct.wx);
            default: ram_addr = grid_addr(r_r, r_c, SZ, SZ);
        endcase
    end

    assign ram_we = req_take && in_grid && (i_req.action == ACT_WRITE);

    hvn_ram #(
        .WIDTH (HW),
        .DEPTH (MAX_ROWS * MAX_COLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (i_req.height),
        .o_rdata (ram_rdata)
    );

    hvn_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_nstart),
        .i_vec   (r_nvec),
        .o_res   (nrm)
    );

    always_comb begin
        n_state  = r_state;
        n_r      = r_r;
        n_c      = r_c;
        n_up     = r_up;
        n_dn     = r_dn;
        n_lf     = r_lf;
        n_rt     = r_rt;
        n_odd    = r_odd;
        n_k      = r_k;
        n_hu     = r_hu;
        n_t      = r_t;
        n_ax     = r_ax;
        n_ay     = r_ay;
        n_az     = r_az;
        n_nstart = 1'b0;
        n_nvec   = r_nvec;
        n_fx     = r_fx;
        n_fy     = r_fy;
        n_fz     = r_fz;
        n_fst    = r_fst;
        n_ox     = r_ox;
        n_oy     = r_oy;
        n_oz     = r_oz;
        n_ost    = r_ost;
        // drop the held result once the sink takes it
        n_ov     = r_ov && !o_res.ready;
        case (r_state)
            ST_IDLE: begin
                if (req_take && i_req.action == ACT_QUERY) begin
                    if (in_grid) begin
                        n_r     = i_req.row;
                        n_c     = i_req.col;
                        n_up    = i_req.row != 8'd0;
                        n_dn    = (RDW'(i_req.row) + 1'b1) < rows_eff;
                        n_lf    = i_req.col != 8'd0;
                        n_rt    = (CDW'(i_req.col) + 1'b1) < cols_eff;
                        n_odd   = i_req.row[0] ^ i_req.col[0];
                        n_state = ST_RDK;
                    end else begin
                        n_fx    = '0;
                        n_fy    = '0;
                        n_fz    = '0;
                        n_fst   = STAT_OUTSIDE;
                        n_state = ST_OUT;
                    end
                end
            end
            ST_RDK: n_state = ST_CAPK;
            ST_CAPK: begin
                n_k     = $signed(ram_rdata);
                n_t     = '0;
                n_ax    = '0;
                n_ay    = '0;
                n_az    = '0;
                n_state = ST_TSEL;
            end
            ST_TSEL: begin
                // skip facets that reach past the grid edge
                if (r_t == t_max) n_state = ST_FIN;
                else if (fct_en) n_state = ST_RDU;
                else n_t = r_t + 1'b1;
            end
            ST_RDU: n_state = ST_RDW;
            ST_RDW: begin
                n_hu    = $signed(ram_rdata);
                n_state = ST_CAPW;
            end
            ST_CAPW: begin
                n_nvec   = '{cx, cy, cz};
                n_nstart = 1'b1;
                n_state  = ST_NWAIT;
            end
            ST_NWAIT: begin
                if (nrm.done) begin
                    n_ax    = r_ax + NCW'(nrm.x);
                    n_ay    = r_ay + NCW'(nrm.y);
                    n_az    = r_az + NCW'(nrm.z);
                    n_t     = r_t + 1'b1;
                    n_state = ST_TSEL;
                end
            end
            ST_FIN: begin
                n_nvec   = '{r_ax, r_ay, r_az};
                n_nstart = 1'b1;
                n_state  = ST_FWAIT;
            end
            ST_FWAIT: begin
                if (nrm.done) begin
                    n_fx    = nrm.x;
                    n_fy    = nrm.y;
                    n_fz    = nrm.z;
                    n_fst   = STAT_OK;
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                // hold until the output register is free
                if (!r_ov || o_res.ready) begin
                    n_ov    = 1'b1;
                    n_ox    = r_fx;
                    n_oy    = r_fy;
                    n_oz    = r_fz;
                    n_ost   = r_fst;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ov     <= 1'b0;
            r_nstart <= 1'b0;
            r_rows   <= DIMW'(256);
            r_cols   <= DIMW'(256);
        end else begin
            r_state  <= n_state;
            r_ov     <= n_ov;
            r_nstart <= n_nstart;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_GRID_ROWS: r_rows <= i_cfg_data;
                    CFG_GRID_COLS: r_cols <= i_cfg_data;
                    default: ;
                endcase
            end
        end
        r_r    <= n_r;
        r_c    <= n_c;
        r_up   <= n_up;
        r_dn   <= n_dn;
        r_lf   <= n_lf;
        r_rt   <= n_rt;
        r_odd  <= n_odd;
        r_k    <= n_k;
        r_hu   <= n_hu;
        r_t    <= n_t;
        r_ax   <= n_ax;
        r_ay   <= n_ay;
        r_az   <= n_az;
        r_nvec <= n_nvec;
        r_fx   <= n_fx;
        r_fy   <= n_fy;
        r_fz   <= n_fz;
        r_fst  <= n_fst;
        r_ox   <= n_ox;
        r_oy   <= n_oy;
        r_oz   <= n_oz;
        r_ost  <= n_ost;
    end

    assign o_res.valid    = r_ov;
    assign o_res.normal_x = r_ox;
    assign o_res.normal_y = r_oy;
    assign o_res.normal_z = r_oz;
    assign o_res.status   = r_ost;
endmodule

// File: src/hvn_ram.sv
module hvn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        o_rdata <= mem[i_addr];
    end
endmodule

// File: src/hvn_norm.sv
module hvn_norm (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  hvn_pkg::t_vec     i_vec,
    output hvn_pkg::t_nrm_out o_res
);
    import hvn_pkg::*;

    t_nrm_state      r_state, n_state;
    logic [MAGW-1:0] r_mag [3];
    logic [MAGW-1:0] n_mag [3];
    logic [2:0]      r_neg, n_neg;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic [29:0]     r_prod, n_prod;
    logic [SQW-1:0]  r_sum, n_sum;
    logic [RTW-1:0]  r_rem, n_rem;
    logic [RTW-1:0]  r_root, n_root;
    logic [NUMW-1:0] r_num [3];
    logic [NUMW-1:0] n_num [3];
    logic [DSHW-1:0] r_dsh, n_dsh;
    logic [QW-1:0]   r_quo [3];
    logic [QW-1:0]   n_quo [3];
    t_nrm_out        r_out, n_out;

    logic [NCW-1:0]  comp [3];
    logic [MAGW-1:0] mx;
    logic [14:0]     sq_in;
    logic [RTW-1:0]  bitv;
    logic [RTW-1:0]  trial;
    logic [QW-1:0]   capq [3];
    logic [NOW-1:0]  sgnq [3];

    assign comp[0] = i_vec.x;
    assign comp[1] = i_vec.y;
    assign comp[2] = i_vec.z;
    assign o_res   = r_out;

    always_comb begin
        mx = r_mag[0];
        if (r_mag[1] > mx) mx = r_mag[1];
        if (r_mag[2] > mx) mx = r_mag[2];
    end

    always_comb begin
        case (r_cnt[1:0])
            2'd0:    sq_in = r_mag[0][14:0];
            2'd1:    sq_in = r_mag[1][14:0];
            2'd2:    sq_in = r_mag[2][14:0];
            default: sq_in = '0;
        endcase
    end

    assign bitv  = RTW'(1) << {r_cnt, 1'b0};
    assign trial = r_root + bitv;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            capq[k] = (r_quo[k] > UNIT_Q) ? UNIT_Q : r_quo[k];
            sgnq[k] = r_neg[k] ? NOW'(-capq[k]) : NOW'(capq[k]);
        end
    end

    always_comb begin
        n_state = r_state;
        n_neg   = r_neg;
        n_cnt   = r_cnt;
        n_prod  = r_prod;
        n_sum   = r_sum;
        n_rem   = r_rem;
        n_root  = r_root;
        n_dsh   = r_dsh;
        n_out   = r_out;
        n_out.done = 1'b0;
        for (int k = 0; k < 3; k++) begin
            n_mag[k] = r_mag[k];
            n_num[k] = r_num[k];
            n_quo[k] = r_quo[k];
        end
        case (r_state)
            NRM_IDLE: begin
                if (i_start) begin
                    for (int k = 0; k < 3; k++) begin
                        n_neg[k] = comp[k][NCW-1];
                        n_mag[k] = comp[k][NCW-1] ? MAGW'(-comp[k]) : MAGW'(comp[k]);
                    end
                    n_state = NRM_SHIFT;
                end
            end
            NRM_SHIFT: begin
                if (mx == '0) begin
                    n_out   = '{1'b1, '0, '0, '0};
                    n_state = NRM_IDLE;
                end else if (mx >= MAGW'(32768)) begin
                    for (int k = 0; k < 3; k++) n_mag[k] = r_mag[k] >> 1;
                end else if (mx < MAGW'(16384)) begin
                    for (int k = 0; k < 3; k++) n_mag[k] = r_mag[k] << 1;
                end else begin
                    n_cnt   = '0;
                    n_sum   = '0;
                    n_state = NRM_SQR;
                end
            end
            NRM_SQR: begin
                // one square per cycle, summed in the next cycle
                n_prod = {15'b0, sq_in} * {15'b0, sq_in};
                if (r_cnt != '0) n_sum = r_sum + SQW'(r_prod);
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNTW'(3)) begin
                    n_rem   = RTW'({r_sum + SQW'(r_prod), 28'b0});
                    n_root  = '0;
                    n_cnt   = CNTW'(ROOT_STEPS - 1);
                    n_state = NRM_ROOT;
                end
            end
            NRM_ROOT: begin
                if (r_rem >= trial) begin
                    n_rem  = r_rem - trial;
                    n_root = (r_root >> 1) + bitv;
                end else begin
                    n_root = r_root >> 1;
                end
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) n_state = NRM_DSET;
            end
            NRM_DSET: begin
                for (int k = 0; k < 3; k++) begin
                    n_num[k] = {r_mag[k][14:0], 28'b0} + NUMW'(r_root[29:1]);
                    n_quo[k] = '0;
                end
                n_dsh   = {1'b0, r_root[29:0], 15'b0};
                n_cnt   = CNTW'(QW - 1);
                n_state = NRM_DIV;
            end
            NRM_DIV: begin
                for (int k = 0; k < 3; k++) begin
                    if ({2'b0, r_num[k]} >= r_dsh) begin
                        n_num[k] = r_num[k] - r_dsh[NUMW-1:0];
                        n_quo[k] = {r_quo[k][QW-2:0], 1'b1};
                    end else begin
                        n_quo[k] = {r_quo[k][QW-2:0], 1'b0};
                    end
                end
                n_dsh = r_dsh >> 1;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) n_state = NRM_DONE;
            end
            NRM_DONE: begin
                n_out   = '{1'b1, sgnq[0], sgnq[1], sgnq[2]};
                n_state = NRM_IDLE;
            end
            default: n_state = NRM_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= NRM_IDLE;
            r_out.done <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_out.done <= n_out.done;
        end
        r_out.x <= n_out.x;
        r_out.y <= n_out.y;
        r_out.z <= n_out.z;
        r_neg   <= n_neg;
        r_cnt   <= n_cnt;
        r_prod  <= n_prod;
        r_sum   <= n_sum;
        r_rem   <= n_rem;
        r_root  <= n_root;
        r_dsh   <= n_dsh;
        for (int k = 0; k < 3; k++) begin
            r_mag[k] <= n_mag[k];
            r_num[k] <= n_num[k];
            r_quo[k] <= n_quo[k];
        end
    end
endmodule
